/* hdl/smm_pkg.sv */
// Shared types and constants for the sparse matrix multiply block.
// No dependencies; imported by every module of the block.
package smm_pkg;

   localparam int MAX_COLS  = 1024;
   localparam int MAX_INNER = 1024;
   localparam int B_CAP     = 4096;
   localparam int ROW_CAP   = 64;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int INNER_W = $clog2(MAX_INNER);
   localparam int BADDR_W = $clog2(B_CAP);
   localparam int BFILL_W = $clog2(B_CAP + 1);
   localparam int RIDX_W  = $clog2(ROW_CAP);
   localparam int RFILL_W = $clog2(ROW_CAP + 1);
   localparam int SWEEP_W = (COL_W > INNER_W) ? COL_W : INNER_W;

   localparam logic [2:0] OP_LOAD_B = 3'd0;
   localparam logic [2:0] OP_A      = 3'd1;
   localparam logic [2:0] OP_D      = 3'd2;
   localparam logic [2:0] OP_EOR    = 3'd3;
   localparam logic [2:0] OP_CLR_B  = 3'd4;

   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_BETA  = 2'd1;

   localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;
   localparam logic signed [31:0] BETA_RESET  = 32'sd0;

   typedef struct packed {
      logic [2:0]         operation;
      logic [9:0]         b_row;
      logic [9:0]         column;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [9:0]         out_column;
      logic signed [31:0] out_value;
      logic               last_in_row;
      logic               empty_row;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic signed [31:0] val;
   } entry_type;

   typedef struct packed {
      logic [BFILL_W-1:0] start;
      logic [BFILL_W-1:0] count;
   } row_ref_type;

   typedef struct packed {
      logic              present;
      logic [RIDX_W-1:0] idx;
   } map_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_A_SCALE,
      ST_A_ROW,
      ST_B_RD,
      ST_B_MUL,
      ST_B_RES,
      ST_D_SCALE,
      ST_ACC_MAP,
      ST_ACC_ADD,
      ST_EMPTY,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [31:0] res;
      logic               sat;
   } mul_out_type;

endpackage

/* hdl/smm_qmul.sv */
// Shared Q16.16 multiplier: registered 32x32 product, then round and saturate.
// Depends on smm_pkg.
module smm_qmul (
   input  logic                 clock,
   input  logic signed [31:0]   mul_a,
   input  logic signed [31:0]   mul_b,
   output smm_pkg::mul_out_type mul_out
);
   import smm_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] rnd;
   logic signed [63:0] quo;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round to nearest, ties up: add half an lsb then floor
   always_comb begin
      rnd = prod_ff + 64'sd32768;
      quo = rnd >>> 16;
      mul_out.sat = 1'b0;
      mul_out.res = quo[31:0];
      if (quo > 64'sd2147483647) begin
         mul_out.res = 32'sh7FFFFFFF;
         mul_out.sat = 1'b1;
      end else if (quo < -64'sd2147483648) begin
         mul_out.res = 32'sh80000000;
         mul_out.sat = 1'b1;
      end
   end

endmodule

/* hdl/sparse_matrix_multiply_csr_top.sv */
// Row-by-row sparse product C = alpha*A*B + beta*D, one request at a time.
// After reset the block runs a clearing pass over the B row table and the
// column map before taking its first request; a clear-B request resets the
// B fill count and runs the same pass over the row table alone. A B load appends
// one entry; a D entry is scaled by beta, an A entry by alpha and then
// multiplied with each entry of the B row it walks, all through the single
// shared multiplier. An end-of-row request scans the column map from column 0
// up to the highest column used, reading and checking each column and
// waiting while the result side stalls; an empty row gives one result.
module sparse_matrix_multiply_csr_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import smm_pkg::*;

   // stores
   entry_type   bst_mem [B_CAP];
   row_ref_type tab_mem [MAX_INNER];
   entry_type   buf_mem [ROW_CAP];
   map_type     map_mem [MAX_COLS];

   entry_type   bst_rd_ff;
   row_ref_type tab_rd_ff;
   entry_type   buf_rd_ff;
   map_type     map_rd_ff;

   logic [BADDR_W-1:0] bst_raddr;
   logic               bst_we;
   logic [BADDR_W-1:0] bst_waddr;
   entry_type          bst_wdata;
   logic [INNER_W-1:0] tab_raddr;
   logic               tab_we;
   logic [INNER_W-1:0] tab_waddr;
   row_ref_type        tab_wdata;
   logic [RIDX_W-1:0]  buf_raddr;
   logic               buf_we;
   logic [RIDX_W-1:0]  buf_waddr;
   entry_type          buf_wdata;
   logic [COL_W-1:0]   map_raddr;
   logic               map_we;
   logic [COL_W-1:0]   map_waddr;
   map_type            map_wdata;

   // control and datapath registers
   state_type          state_ff, state_in;
   logic signed [31:0] alpha_ff, beta_ff;
   logic [2:0]         op_unused;
   logic [INNER_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] a_ff, a_in;
   logic [BFILL_W-1:0] p_ff, p_in;
   logic [BFILL_W-1:0] end_ff, end_in;
   logic [COL_W-1:0]   acc_col_ff, acc_col_in;
   logic signed [31:0] acc_val_ff, acc_val_in;
   logic [RIDX_W-1:0]  idx_ff, idx_in;
   logic               from_a_ff, from_a_in;
   logic [RFILL_W-1:0] fill_ff, fill_in;
   logic               flag_ff, flag_in;
   logic [BFILL_W-1:0] bfill_ff, bfill_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic               sweep_map_ff, sweep_map_in;
   logic [COL_W-1:0]   scan_ff, scan_in;
   logic [RFILL_W-1:0] emit_ff, emit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [31:0] mul_a, mul_b;
   mul_out_type        mul_out;
   logic               out_free;
   logic               accept;
   logic signed [32:0] sum;
   logic [BFILL_W-1:0] tab_end;
   state_type          ret_state;

   smm_qmul u_qmul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_out (mul_out)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign op_unused = req_data.operation;
   assign sum       = {buf_rd_ff.val[31], buf_rd_ff.val} + {acc_val_ff[31], acc_val_ff};
   assign tab_end   = tab_rd_ff.start + tab_rd_ff.count;
   assign ret_state = from_a_ff ? ST_B_RD : ST_IDLE;

   always_ff @(posedge clock) begin
      if (bst_we) begin
         bst_mem[bst_waddr] <= bst_wdata;
      end
      bst_rd_ff <= bst_mem[bst_raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rd_ff <= tab_mem[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rd_ff <= buf_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_data;
            CSR_BETA:  beta_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fill_ff      <= '0;
         flag_ff      <= 1'b0;
         bfill_ff     <= '0;
         sweep_ff     <= '0;
         sweep_map_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         flag_ff      <= flag_in;
         bfill_ff     <= bfill_in;
         sweep_ff     <= sweep_in;
         sweep_map_ff <= sweep_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      a_ff        <= a_in;
      p_ff        <= p_in;
      end_ff      <= end_in;
      acc_col_ff  <= acc_col_in;
      acc_val_ff  <= acc_val_in;
      idx_ff      <= idx_in;
      from_a_ff   <= from_a_in;
      scan_ff     <= scan_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      end_in       = end_ff;
      acc_col_in   = acc_col_ff;
      acc_val_in   = acc_val_ff;
      idx_in       = idx_ff;
      from_a_in    = from_a_ff;
      fill_in      = fill_ff;
      flag_in      = flag_ff;
      bfill_in     = bfill_ff;
      sweep_in     = sweep_ff;
      sweep_map_in = sweep_map_ff;
      scan_in      = scan_ff;
      emit_in      = emit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mul_a     = val_ff;
      mul_b     = bst_rd_ff.val;
      bst_raddr = p_ff[BADDR_W-1:0];
      bst_we    = 1'b0;
      bst_waddr = bfill_ff[BADDR_W-1:0];
      bst_wdata = '{col: col_ff, val: val_ff};
      tab_raddr = row_ff;
      tab_we    = 1'b0;
      tab_waddr = row_ff;
      tab_wdata = '0;
      buf_raddr = idx_ff;
      buf_we    = 1'b0;
      buf_waddr = idx_ff;
      buf_wdata = '{col: acc_col_ff, val: acc_val_ff};
      map_raddr = acc_col_ff;
      map_we    = 1'b0;
      map_waddr = acc_col_ff;
      map_wdata = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            tab_we    = 1'b1;
            tab_waddr = sweep_ff[INNER_W-1:0];
            map_we    = sweep_map_ff;
            map_waddr = sweep_ff[COL_W-1:0];
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_W'(SWEEP_W'(MAX_INNER > MAX_COLS ? MAX_INNER : MAX_COLS) - 1))
            begin
               sweep_in     = '0;
               sweep_map_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in = req_data.b_row[INNER_W-1:0];
               col_in = req_data.column[COL_W-1:0];
               val_in = req_data.value;
               mul_a  = req_data.value;
               unique case (op_unused)
                  OP_LOAD_B: begin
                     tab_raddr = req_data.b_row[INNER_W-1:0];
                     if (bfill_ff != BFILL_W'(B_CAP)) begin
                        state_in = ST_LOAD_WR;
                     end
                  end
                  OP_A: begin
                     mul_b    = alpha_ff;
                     state_in = ST_A_SCALE;
                  end
                  OP_D: begin
                     mul_b = beta_ff;
                     if (beta_ff != 32'sd0) begin
                        state_in = ST_D_SCALE;
                     end
                  end
                  OP_EOR: begin
                     scan_in = '0;
                     emit_in = '0;
                     state_in = (fill_ff == '0) ? ST_EMPTY : ST_SCAN_RD;
                  end
                  OP_CLR_B: begin
                     bfill_in = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD_WR: begin
            state_in = ST_IDLE;
            // a row may only grow while it is the last one appended
            if (tab_rd_ff.count == '0 || tab_end == bfill_ff) begin
               bst_we    = 1'b1;
               tab_we    = 1'b1;
               tab_wdata.start = (tab_rd_ff.count == '0) ? bfill_ff : tab_rd_ff.start;
               tab_wdata.count = tab_rd_ff.count + 1'b1;
               bfill_in  = bfill_ff + 1'b1;
            end
         end
         ST_A_SCALE: begin
            a_in      = mul_out.res;
            flag_in   = flag_ff | mul_out.sat;
            tab_raddr = col_ff;
            state_in  = ST_A_ROW;
         end
         ST_A_ROW: begin
            p_in     = tab_rd_ff.start;
            end_in   = tab_end;
            state_in = ST_B_RD;
         end
         ST_B_RD: begin
            if (p_ff == end_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_B_MUL;
            end
         end
         ST_B_MUL: begin
            mul_a      = a_ff;
            mul_b      = bst_rd_ff.val;
            acc_col_in = bst_rd_ff.col;
            state_in   = ST_B_RES;
         end
         ST_B_RES: begin
            acc_val_in = mul_out.res;
            flag_in    = flag_ff | mul_out.sat;
            p_in       = p_ff + 1'b1;
            from_a_in  = 1'b1;
            state_in   = ST_ACC_MAP;
         end
         ST_D_SCALE: begin
            acc_val_in = mul_out.res;
            flag_in    = flag_ff | mul_out.sat;
            acc_col_in = col_ff;
            map_raddr  = col_ff;
            from_a_in  = 1'b0;
            state_in   = ST_ACC_MAP;
         end
         ST_ACC_MAP: begin
            if (map_rd_ff.present) begin
               idx_in    = map_rd_ff.idx;
               buf_raddr = map_rd_ff.idx;
               state_in  = ST_ACC_ADD;
            end else if (fill_ff == RFILL_W'(ROW_CAP)) begin
               // row full: drop the new column
               flag_in  = 1'b1;
               state_in = ret_state;
            end else begin
               buf_we    = 1'b1;
               buf_waddr = fill_ff[RIDX_W-1:0];
               map_we    = 1'b1;
               map_wdata = '{present: 1'b1, idx: fill_ff[RIDX_W-1:0]};
               fill_in   = fill_ff + 1'b1;
               state_in  = ret_state;
            end
         end
         ST_ACC_ADD: begin
            buf_we = 1'b1;
            if (sum[32] != sum[31]) begin
               flag_in       = 1'b1;
               buf_wdata.val = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
               buf_wdata.val = sum[31:0];
            end
            state_in = ret_state;
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_column: '0, out_value: '0, last_in_row: 1'b1,
                                empty_row: 1'b1, overflow: flag_ff};
               flag_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            map_raddr = scan_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (map_rd_ff.present) begin
               map_we    = 1'b1;
               map_waddr = scan_ff;
               idx_in    = map_rd_ff.idx;
               buf_raddr = map_rd_ff.idx;
               state_in  = ST_EMIT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_column: scan_ff, out_value: buf_rd_ff.val,
                                last_in_row: (emit_ff == fill_ff - 1'b1),
                                empty_row: 1'b0, overflow: flag_ff};
               if (emit_ff == fill_ff - 1'b1) begin
                  fill_in  = '0;
                  flag_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  scan_in  = scan_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= RFILL_W'(ROW_CAP))
      else $error("row fill beyond capacity");

   a_bfill_bound: assert property (@(posedge clock) disable iff (reset)
      bfill_ff <= BFILL_W'(B_CAP))
      else $error("B fill beyond capacity");

   a_row_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && emit_ff == fill_ff - 1'b1)
      |=> (fill_ff == '0 && !flag_ff && state_ff == ST_IDLE))
      else $error("row state not cleared after last result");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_row) |-> (rsp_data.last_in_row && rsp_data.out_value == '0))
      else $error("empty row result malformed");

endmodule
